[hw/rtl/psl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psl_pkg
// shared opcodes, field widths and the result record of the position list
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int POS_W  = 6;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic                     is_empty;
    logic [POS_W-1:0]         count;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] element;
    logic                     ok;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/psl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module psl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                                    clk,
  input  wire                                    wr_en,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire [WIDTH-1:0]                        wr_data,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/psl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psl_ctrl
// sequencer that walks the entry ram one step at a time for insert, remove
// and locate, using one shared read/compare/write path
// ----------------------------------------------------------------------------
module psl_ctrl #(
  parameter int CAPACITY = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire psl_pkg::opcode_t        in_opcode,
  input  wire [psl_pkg::POS_W-1:0]     in_position,
  input  wire [psl_pkg::DATA_W-1:0]    in_value,
  output logic                         res_valid,
  input  wire                          res_ready,
  output psl_pkg::result_t             res
);

  import psl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                state;
  opcode_t               op;
  logic [POS_W-1:0]      pos;
  logic [DATA_W-1:0]     value;
  logic [CW-1:0]         k;
  logic [CW-1:0]         count;
  logic [DATA_W-1:0]     element;
  logic [POS_W-1:0]      found;
  logic                  ok;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;

  logic [PW-1:0]         in_pos_w;
  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         k_w;
  logic [PW-1:0]         pos_w;
  logic                  ins_ok;
  logic                  rem_ok;

  assign in_pos_w = PW'(in_position);
  assign cnt_w    = PW'(count);
  assign k_w      = PW'(k);
  assign pos_w    = PW'(pos);
  assign ins_ok   = (in_pos_w != '0) && (cnt_w < CAP) && (in_pos_w <= cnt_w + PW'(1));
  assign rem_ok   = (in_pos_w != '0) && (in_pos_w <= cnt_w);

  psl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // shared read/write addressing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(k);
    ram_wdata = ram_rdata;
    ram_raddr = (op == OP_INSERT) ? AW'(k - CW'(1)) : AW'(k);
    case (state)
      S_WR: begin
        if (op == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(k);
        end else if (op == OP_REMOVE && k_w != pos_w - PW'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(k - CW'(1));
        end
      end
      S_FIN: begin
        if (op == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pos_w - PW'(1));
          ram_wdata = value;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= in_opcode;
            pos     <= in_position;
            value   <= in_value;
            element <= '0;
            found   <= '0;
            case (in_opcode)
              OP_INSERT: begin
                ok <= ins_ok;
                k  <= count;
                if (!ins_ok) begin
                  state <= S_DONE;
                end else if (cnt_w >= in_pos_w) begin
                  state <= S_RD;
                end else begin
                  state <= S_FIN;
                end
              end
              OP_REMOVE: begin
                ok    <= rem_ok;
                k     <= CW'(in_pos_w - PW'(1));
                state <= rem_ok ? S_RD : S_DONE;
              end
              OP_LOCATE: begin
                ok    <= 1'b1;
                k     <= '0;
                state <= (count == '0) ? S_DONE : S_RD;
              end
              default: begin
                ok    <= 1'b1;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          case (op)
            OP_INSERT: begin
              k     <= k - CW'(1);
              state <= (k_w > pos_w) ? S_RD : S_FIN;
            end
            OP_REMOVE: begin
              if (k_w == pos_w - PW'(1)) begin
                element <= ram_rdata;
              end
              k     <= k + CW'(1);
              state <= (k_w + PW'(1) < cnt_w) ? S_RD : S_FIN;
            end
            default: begin
              if (ram_rdata == value) begin
                found <= POS_W'(k_w + PW'(1));
                state <= S_DONE;
              end else begin
                k     <= k + CW'(1);
                state <= (k_w + PW'(1) < cnt_w) ? S_RD : S_DONE;
              end
            end
          endcase
        end
        S_FIN: begin
          if (op == OP_INSERT) begin
            count <= count + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready           = (state == S_IDLE);
  assign res_valid          = (state == S_DONE);
  assign res.ok             = ok;
  assign res.element        = element;
  assign res.found_position = found;
  assign res.count          = POS_W'(count);
  assign res.is_empty       = (count == '0);

endmodule
`default_nettype wire

[hw/rtl/positional_sequence_list_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// positional_sequence_list_unit
// ordered list of signed 32-bit entries with insert, remove, locate and query
// ----------------------------------------------------------------------------
// steps: a query or failed request goes straight to the done state and out;
//   insert walks down from the last entry to the position, remove walks up from
//   it and locate up to a match, over the entry ram's shared read/write path
// throughput: one item at a time; a new item is taken while a result waits
// reset: clears the entry count and the sequencer; entry ram is not cleared
module positional_sequence_list_unit #(
  parameter int CAPACITY = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [39:0]  s_tdata,   // position[5:0], value[37:6], zero pad
  input  wire [1:0]   s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata    // ok[0], element[32:1], found_position[38:33],
                                 // count[44:39], is_empty[45], zero pad
);

  import psl_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  psl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_opcode   (opcode_t'(s_tuser)),
    .in_position (s_tdata[5:0]),
    .in_value    (s_tdata[37:6]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res};

endmodule
`default_nettype wire
